// ===== sv/mini_riscv_executor_with_stall_count_core_assert.svh =====
// Assertion macros used by the executor core
`ifndef MINI_RISCV_EXECUTOR_WITH_STALL_COUNT_CORE_ASSERT_SVH
`define MINI_RISCV_EXECUTOR_WITH_STALL_COUNT_CORE_ASSERT_SVH

// implication checked every cycle outside reset
`define MRX_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MRX_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/mrx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrx_pkg
// Types and constants of the mini RISC-V executor.
// ----------------------------------------------------------------------------
package mrx_pkg;

  localparam int DATA_WORDS    = 1024;
  localparam int PROGRAM_LINES = 1024;
  localparam int REG_COUNT     = 32;
  localparam int DAW = $clog2(DATA_WORDS);
  localparam int RAW = $clog2(REG_COUNT);

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_ADDI = 5'd1, OP_SUB = 5'd2, OP_LI = 5'd3,
    OP_BEQ = 5'd4, OP_BLE = 5'd5, OP_BLT = 5'd6, OP_BGT = 5'd7,
    OP_BGE = 5'd8, OP_J = 5'd9, OP_SRLI = 5'd10, OP_SLLI = 5'd11,
    OP_SLT = 5'd12, OP_LW = 5'd13, OP_SW = 5'd14, OP_LA = 5'd15,
    OP_LABEL = 5'd16, OP_PRELOAD = 5'd17
  } opcode_e;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [4:0]  dest_reg;
    logic [4:0]  src_a_reg;
    logic [4:0]  src_b_reg;
    logic signed [31:0] immediate;
    logic [9:0]  label_index;
    logic        label_found;
  } instr_t;

  typedef struct packed {
    logic [9:0]  next_line;
    logic        branch_taken;
    logic        reg_write;
    logic [4:0]  written_reg;
    logic signed [31:0] written_value;
    logic        address_fault;
    logic [31:0] stall_total;
    logic [31:0] retired_total;
  } result_t;

  // memory request from execute stage to data store
  typedef struct packed {
    logic            rd_en;
    logic            wr_en;
    logic [DAW-1:0]  addr;
    logic [31:0]     wdata;
  } dmem_req_t;

  function automatic logic [9:0] wrap_line(input logic [16:0] x);
    logic [16:0] m;
    m = x % 17'(PROGRAM_LINES);
    return m[9:0];
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [2:0] n);
    logic [32:0] s;
    s = {1'b0, a} + 33'(n);
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== sv/mrx_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrx_stream_if
// Valid/ready channels carrying one instr_t or result_t word.
// ----------------------------------------------------------------------------
interface mrx_instr_if;
  import mrx_pkg::*;
  logic   valid;
  logic   ready;
  instr_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mrx_result_if;
  import mrx_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/mrx_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrx_regfile
// 32-entry register file with reset-clear valid bits, three combinational reads.
// ----------------------------------------------------------------------------
module mrx_regfile (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [4:0]  ra_i,
  input  logic [4:0]  rb_i,
  input  logic [4:0]  rd_i,
  output logic [31:0] va_o,
  output logic [31:0] vb_o,
  output logic [31:0] vd_o,
  input  logic        we_i,
  input  logic [4:0]  wa_i,
  input  logic [31:0] wd_i
);
  import mrx_pkg::*;
  logic [31:0] regs_q [REG_COUNT];
  logic [REG_COUNT-1:0] vld_q;

  // small flop array; reset clears through valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[wa_i] <= 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (we_i) regs_q[wa_i] <= wd_i;
  end

  assign va_o = vld_q[ra_i] ? regs_q[ra_i] : '0;
  assign vb_o = vld_q[rb_i] ? regs_q[rb_i] : '0;
  assign vd_o = vld_q[rd_i] ? regs_q[rd_i] : '0;
endmodule

// ===== sv/mrx_dmem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrx_dmem
// Word data store, one port, registered read.
// ----------------------------------------------------------------------------
module mrx_dmem (
  input  logic              clk_i,
  input  mrx_pkg::dmem_req_t req_i,
  output logic [31:0]       rdata_o
);
  import mrx_pkg::*;
  logic [31:0] mem [DATA_WORDS];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) mem[req_i.addr] <= req_i.wdata;
    if (req_i.rd_en) rdata_o <= mem[req_i.addr];
  end
endmodule

// ===== sv/mini_riscv_executor_with_stall_count_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mini_riscv_executor_with_stall_count_core
// Executes one pre-decoded RV32I-subset instruction per word.
// ----------------------------------------------------------------------------
// Each accepted word is registered in stage 2 after execute, then in the output register after memory/writeback.
// Throughput: 1 word per cycle while the output is not stalled; lw data forwards from the data store port.
// Reset: registers, counters and history clear at once; data store contents
// are undefined until written. No clearing pass.
module mini_riscv_executor_with_stall_count_core (
  input logic clk_i,
  input logic rst_ni,
  mrx_instr_if.sink    in_i,
  mrx_result_if.source out_o
);
  import mrx_pkg::*;
  `include "mini_riscv_executor_with_stall_count_core_assert.svh"

  instr_t i;
  assign i = in_i.data;

  // stage 2 (memory/writeback) registers
  logic        s2_vld_q;
  logic        s2_load_q;
  result_t     s2_res_q;
  result_t     s2_out;
  logic [31:0] ld_data;

  // output register
  logic    ov_q;
  result_t ores_q;

  logic adv, fire;
  assign adv  = !ov_q || out_o.ready;
  assign in_i.ready = adv;
  assign fire = in_i.valid && in_i.ready;

  // architectural state
  logic [9:0]  line_q;
  logic [31:0] stall_q, ret_q;
  logic [1:0]  hw_q;
  logic [4:0]  hr0_q, hr1_q;

  // register file; writes from stage 2, forward to reads
  logic [31:0] rf_a, rf_b, rf_d, va, vb, vd, s2_wval;
  logic        rf_we;
  assign s2_wval = s2_load_q ? ld_data : s2_res_q.written_value;
  assign rf_we   = s2_vld_q && s2_res_q.reg_write && adv;

  // stage 2 word with load data merged in
  always_comb begin
    s2_out = s2_res_q;
    s2_out.written_value = s2_wval;
  end

  mrx_regfile u_rf (
    .clk_i, .rst_ni,
    .ra_i(i.src_a_reg), .rb_i(i.src_b_reg), .rd_i(i.dest_reg),
    .va_o(rf_a), .vb_o(rf_b), .vd_o(rf_d),
    .we_i(rf_we), .wa_i(s2_res_q.written_reg), .wd_i(s2_wval)
  );

  logic fwd_ok;
  assign fwd_ok = s2_vld_q && s2_res_q.reg_write;
  assign va = (fwd_ok && s2_res_q.written_reg == i.src_a_reg) ? s2_wval : rf_a;
  assign vb = (fwd_ok && s2_res_q.written_reg == i.src_b_reg) ? s2_wval : rf_b;
  assign vd = (fwd_ok && s2_res_q.written_reg == i.dest_reg)  ? s2_wval : rf_d;

  // execute
  dmem_req_t req;
  result_t   r;
  logic      is_load, writer;
  logic [2:0] st1, st2;
  logic signed [32:0] wa;
  logic signed [31:0] qa, qb;
  logic hit_a, hit_b, hit_d, cond, lt, eq;
  logic [9:0] nxt;

  function automatic logic hit(input logic [1:0] w, input logic [4:0] h0,
                               input logic [4:0] h1, input logic [4:0] x);
    return (w[0] && h0 == x) || (w[1] && h1 == x);
  endfunction

  always_comb begin
    hit_a = hit(hw_q, hr0_q, hr1_q, i.src_a_reg);
    hit_b = hit(hw_q, hr0_q, hr1_q, i.src_b_reg);
    hit_d = hit(hw_q, hr0_q, hr1_q, i.dest_reg);
    // truncating divide by 4 toward zero
    qa = $signed(va) / 4;
    qb = i.immediate / 4;
    wa = 33'(qa) + 33'(qb);
    lt = $signed(va) < $signed(vb);
    eq = va == vb;
    case (opcode_e'(i.opcode))
      OP_BEQ:  cond = eq;
      OP_BLE:  cond = lt || eq;
      OP_BLT:  cond = lt;
      OP_BGT:  cond = !(lt || eq);
      OP_BGE:  cond = !lt;
      default: cond = 1'b0;
    endcase
    nxt = wrap_line(17'(line_q) + 17'd1);
    st1 = '0; st2 = '0;
    r = '0; req = '0; is_load = 1'b0; writer = 1'b0;
    case (opcode_e'(i.opcode))
      OP_ADD, OP_SUB, OP_SLT: begin
        if (hit_a || hit_b) st1 = 3'd2;
        r.reg_write = 1'b1;
        writer = (i.opcode != OP_SLT);
        r.written_value = (i.opcode == OP_ADD) ? va + vb :
                          (i.opcode == OP_SUB) ? va - vb : {31'd0, lt};
      end
      OP_ADDI, OP_SRLI, OP_SLLI: begin
        if (hit_a) st1 = 3'd2;
        r.reg_write = 1'b1; writer = 1'b1;
        r.written_value = (i.opcode == OP_ADDI) ? va + i.immediate :
                          (i.opcode == OP_SRLI) ? va >> i.immediate[4:0] :
                                                  va << i.immediate[4:0];
      end
      OP_LI: begin
        r.reg_write = 1'b1; writer = 1'b1; r.written_value = i.immediate;
      end
      OP_BEQ, OP_BLE, OP_BLT, OP_BGT, OP_BGE: begin
        st1 = 3'd2;
        if (cond && i.label_found) begin
          if (hw_q[1]) begin
            if (hw_q[0] && (hr0_q == i.src_a_reg || hr0_q == i.src_b_reg)) st2 = 3'd2;
            else if (hr1_q == i.src_a_reg || hr1_q == i.src_b_reg) st2 = 3'd1;
          end
          r.branch_taken = 1'b1;
          nxt = wrap_line(17'(i.label_index) + 17'd1);
        end
      end
      OP_J: begin
        st1 = 3'd2;
        if (i.label_found) begin
          r.branch_taken = 1'b1;
          nxt = wrap_line(17'(i.label_index) + 17'd1);
        end
      end
      OP_LW, OP_SW: begin
        writer = 1'b1;
        if (i.opcode == OP_LW ? hit_d : hit_a) st1 = 3'd2;
        if (wa < 0 || wa >= 33'(DATA_WORDS)) begin
          r.address_fault = 1'b1;
        end else begin
          req.addr = wa[DAW-1:0];
          if (i.opcode == OP_LW) begin
            r.reg_write = 1'b1; is_load = 1'b1; req.rd_en = fire;
          end else begin
            r.written_value = vd; req.wdata = vd; req.wr_en = fire;
          end
        end
      end
      OP_LA: begin
        writer = 1'b1;
        if (i.label_found) begin
          st1 = 3'd2;
          if (hit_d) st2 = 3'd2;
          r.reg_write = 1'b1;
          r.written_value = {20'd0, i.label_index, 2'b00};
        end
      end
      OP_PRELOAD: begin
        nxt = line_q;
        r.written_value = i.immediate;
        if (32'(i.label_index) < 32'(DATA_WORDS)) begin
          req.addr = DAW'(i.label_index); req.wdata = i.immediate; req.wr_en = fire;
        end else begin
          r.address_fault = 1'b1;
        end
      end
      default: ;
    endcase
    r.next_line = nxt;
    r.written_reg = r.reg_write ? i.dest_reg : 5'd0;
    r.stall_total = sat_add(sat_add(stall_q, st1), st2);
    r.retired_total = (ret_q == 32'hFFFF_FFFF) ? ret_q : ret_q + 32'd1;
  end

  mrx_dmem u_dm (.clk_i, .req_i(req), .rdata_o(ld_data));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0; stall_q <= '0; ret_q <= '0;
      hw_q <= '0; hr0_q <= '0; hr1_q <= '0;
      s2_vld_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      if (fire) begin
        stall_q <= r.stall_total;
        ret_q   <= r.retired_total;
        if (i.opcode != OP_PRELOAD) begin
          line_q <= nxt;
          hw_q   <= {hw_q[0], writer};
          hr1_q  <= hr0_q; hr0_q <= i.dest_reg;
        end
      end
      if (adv) begin
        s2_vld_q <= fire;
        ov_q     <= s2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // a stalled load keeps its registered read data until it moves on
      s2_res_q  <= r;
      s2_load_q <= is_load;
      ores_q    <= s2_out;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = ores_q;

  `MRX_ASSERT_IMP(a_stall_mono, clk_i, rst_ni, fire, r.stall_total >= stall_q)
  `MRX_ASSERT_NXT(a_s2_flow, clk_i, rst_ni, fire, s2_vld_q)
  `MRX_ASSERT_IMP(a_hold_rdy, clk_i, rst_ni, ov_q && !out_o.ready, !in_i.ready)
endmodule
